// ----- design/tmt_pkg.sv -----
`default_nettype none

package tmt_pkg;

    localparam int MAX_CORNERS = 12;
    localparam int MIN_CORNERS = 3;
    localparam int K_W = $clog2(MAX_CORNERS + 1);

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [1:0] EMIT_CENTRE = 2'd0;
    localparam logic [1:0] EMIT_RING = 2'd1;
    localparam logic [1:0] EMIT_TRI = 2'd2;

    typedef struct packed {
        logic load;
        logic cross_mul;
        logic vec_load;
        logic vec_sel;
        logic norm_step;
        logic sq;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic vec_store;
        logic vec_zero;
        logic ring_mul;
        logic ring_nrm;
        logic ring_rmul;
        logic ring_pos;
        logic emit;
        logic [1:0] emit_sel;
        logic last;
        logic [K_W-1:0] k;
        logic tri_cap;
        logic tri_sub;
    } tmt_cmd_t;

    typedef struct packed {
        logic zero_vec;
        logic norm_done;
        logic out_free;
        logic [K_W-1:0] n;
    } tmt_stat_t;

endpackage

`default_nettype wire

// ----- design/tmt_if.sv -----
`default_nettype none

interface tmt_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic [31:0] end_color;

    modport source (output valid, end_x, end_y, end_z, dir_x, dir_y, dir_z,
                    ref_x, ref_y, ref_z, end_color, input ready);
    modport sink (input valid, end_x, end_y, end_z, dir_x, dir_y, dir_z,
                  ref_x, ref_y, ref_z, end_color, output ready);
endinterface

interface tmt_out_if;
    logic valid;
    logic ready;
    logic kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [31:0] rgba;
    logic [4:0] corner_a;
    logic [4:0] corner_b;
    logic [4:0] corner_c;
    logic last;

    modport source (output valid, kind, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                    rgba, corner_a, corner_b, corner_c, last, input ready);
    modport sink (input valid, kind, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  rgba, corner_a, corner_b, corner_c, last, output ready);
endinterface

`default_nettype wire

// ----- design/tube_mesh_tessellator.sv -----
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    end_x..z, dir_x..z, ref_x..z, end_color
// out_ch    out  valid/ready    kind, pos_x..z, nrm_x..z, rgba, corner_a..c, last
// APB       in   psel/penable   tube_radius at 0x0, corner_count at 0x4
//
// One item at a time. Each end works out two basis vectors; a nonzero one takes
// the normalize steps, 32 square-root steps and 17 divider steps, a zero one
// skips them. Then the ring states RMUL, RNRM, RRAD, RPOS and ROUT run per
// corner; the second end adds 4n triangles after its centre vertex.
// Reset clears the registers to radius 1.0 and 8 corners, and expects a first end.
// A stalled output holds the sequencer; a new item is taken as soon as the
// last result of the previous one sits in the output register.
`default_nettype none

module tube_mesh_tessellator
    import tmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tmt_in_if.sink      in_ch,
    tmt_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tmt_cmd_t cmd;
    tmt_stat_t stat;
    logic [30:0] radius_reg;
    logic [3:0] corner_reg;
    logic cfg_wr;

    // register index is the word address; byte offset bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {28'b0, corner_reg} : {1'b0, radius_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            corner_reg <= 4'd8;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                corner_reg <= pwdata[3:0];
            else
                radius_reg <= pwdata[30:0];
        end
    end

    // sequencer: owns item order, loop counts and which end comes next
    tmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic: basis vectors, ring vertices, triangles and the output register
    tmt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .radius       (radius_reg),
        .corner_count (corner_reg),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );

endmodule

`default_nettype wire

// ----- design/tmt_ctrl.sv -----
`default_nettype none

module tmt_ctrl
    import tmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output tmt_cmd_t  cmd,
    input  tmt_stat_t stat
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_VLOAD  = 5'd1;
    localparam logic [4:0] S_VCHK   = 5'd2;
    localparam logic [4:0] S_NORM   = 5'd3;
    localparam logic [4:0] S_SQ     = 5'd4;
    localparam logic [4:0] S_SUM    = 5'd5;
    localparam logic [4:0] S_SQRT   = 5'd6;
    localparam logic [4:0] S_DIVI   = 5'd7;
    localparam logic [4:0] S_DIV    = 5'd8;
    localparam logic [4:0] S_VSTORE = 5'd9;
    localparam logic [4:0] S_CROSS  = 5'd10;
    localparam logic [4:0] S_CENTRE = 5'd11;
    localparam logic [4:0] S_RMUL   = 5'd12;
    localparam logic [4:0] S_RNRM   = 5'd13;
    localparam logic [4:0] S_RRAD   = 5'd14;
    localparam logic [4:0] S_RPOS   = 5'd15;
    localparam logic [4:0] S_ROUT   = 5'd16;
    localparam logic [4:0] S_TRI    = 5'd17;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 17;

    logic [4:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [K_W-1:0] k_reg, k_next;
    logic vsel_reg, vsel_next;
    logic second_reg, second_next;
    logic cap_reg, cap_next;
    logic sub_reg, sub_next;
    logic k_last;

    assign k_last = (k_reg == stat.n - K_W'(1));
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        vsel_next = vsel_reg;
        second_next = second_reg;
        cap_next = cap_reg;
        sub_next = sub_reg;
        cmd = '0;
        cmd.k = k_reg;
        cmd.vec_sel = vsel_reg;
        cmd.tri_cap = cap_reg;
        cmd.tri_sub = sub_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    vsel_next = 1'b0;
                    state_next = S_VLOAD;
                end
            end
            S_VLOAD:
            begin
                cmd.vec_load = 1'b1;
                state_next = S_VCHK;
            end
            S_VCHK, S_VSTORE:
            begin
                if (state_reg == S_VCHK && !stat.zero_vec)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    // finish this basis vector, then the next one or the vertices
                    cmd.vec_zero = (state_reg == S_VCHK);
                    cmd.vec_store = (state_reg == S_VSTORE);
                    k_next = '0;
                    if (!vsel_reg)
                        state_next = S_CROSS;
                    else if (second_reg)
                        state_next = S_RMUL;
                    else
                        state_next = S_CENTRE;
                end
            end
            S_NORM:
            begin
                if (stat.norm_done)
                    state_next = S_SQ;
                else
                    cmd.norm_step = 1'b1;
            end
            S_SQ:
            begin
                cmd.sq = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = S_VSTORE;
            end
            S_CROSS:
            begin
                cmd.cross_mul = 1'b1;
                vsel_next = 1'b1;
                state_next = S_VLOAD;
            end
            S_CENTRE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = EMIT_CENTRE;
                    k_next = '0;
                    cap_next = 1'b0;
                    sub_next = 1'b0;
                    state_next = second_reg ? S_TRI : S_RMUL;
                end
            end
            S_RMUL:
            begin
                cmd.ring_mul = 1'b1;
                state_next = S_RNRM;
            end
            S_RNRM:
            begin
                cmd.ring_nrm = 1'b1;
                state_next = S_RRAD;
            end
            S_RRAD:
            begin
                cmd.ring_rmul = 1'b1;
                state_next = S_RPOS;
            end
            S_RPOS:
            begin
                cmd.ring_pos = 1'b1;
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = EMIT_RING;
                    cmd.last = !second_reg && k_last;
                    if (!k_last)
                    begin
                        k_next = k_reg + K_W'(1);
                        state_next = S_RMUL;
                    end
                    else if (second_reg)
                    begin
                        state_next = S_CENTRE;
                    end
                    else
                    begin
                        second_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_TRI:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = EMIT_TRI;
                    cmd.last = cap_reg && sub_reg && k_last;
                    sub_next = !sub_reg;
                    if (sub_reg)
                    begin
                        if (!k_last)
                        begin
                            k_next = k_reg + K_W'(1);
                        end
                        else if (!cap_reg)
                        begin
                            cap_next = 1'b1;
                            k_next = '0;
                        end
                        else
                        begin
                            second_next = 1'b0;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            k_reg <= '0;
            vsel_reg <= 1'b0;
            second_reg <= 1'b0;
            cap_reg <= 1'b0;
            sub_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
            vsel_reg <= vsel_next;
            second_reg <= second_next;
            cap_reg <= cap_next;
            sub_reg <= sub_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tmt_dp.sv -----
`default_nettype none

module tmt_dp
    import tmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tmt_cmd_t    cmd,
    output tmt_stat_t   stat,
    input  logic [30:0] radius,
    input  logic [3:0]  corner_count,
    tmt_in_if.sink      in_ch,
    tmt_out_if.source   out_ch
);

    logic signed [31:0] in_ctr [3];
    logic signed [31:0] in_dir [3];
    logic signed [31:0] in_ref [3];

    logic signed [31:0] ctr_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] ref_reg [3];
    logic [31:0] rgba_reg;
    logic [K_W-1:0] n_reg;
    logic [K_W-1:0] n_clamp;

    logic signed [63:0] pa_reg [3];
    logic signed [63:0] pb_reg [3];
    logic signed [64:0] diff [3];
    logic neg_reg [3];
    logic [63:0] a_reg [3];
    logic [63:0] amax;
    logic [59:0] sq_reg [3];
    logic [63:0] v_reg, r_reg, bit_reg, rb;
    logic [30:0] len;
    logic [46:0] numf [3];
    logic [31:0] trial [3];
    logic [31:0] rem_reg [3];
    logic [16:0] num_reg [3];
    logic [16:0] quo_reg [3];
    logic signed [17:0] uq [3];
    logic signed [17:0] nh_reg [3];
    logic signed [17:0] sh_reg [3];

    logic signed [17:0] cos_tab [0:MAX_CORNERS][0:MAX_CORNERS-1];
    logic signed [17:0] sin_tab [0:MAX_CORNERS][0:MAX_CORNERS-1];
    logic signed [17:0] cs_w, sn_w;
    logic signed [35:0] m1_reg [3];
    logic signed [35:0] m2_reg [3];
    logic signed [36:0] s37 [3];
    logic signed [18:0] nrm_reg [3];
    logic signed [50:0] rp_reg [3];
    logic signed [34:0] rnd35 [3];
    logic signed [35:0] psum [3];
    logic signed [31:0] pos_reg [3];

    logic [4:0] n5, ka, kb, ta, tb, tc;
    logic ovalid_reg;
    logic okind_reg, olast_reg;
    logic signed [31:0] opos_reg [3];
    logic signed [31:0] onrm_reg [3];
    logic [31:0] orgba_reg;
    logic [4:0] oca_reg, ocb_reg, occ_reg;

    assign in_ctr[0] = in_ch.end_x;
    assign in_ctr[1] = in_ch.end_y;
    assign in_ctr[2] = in_ch.end_z;
    assign in_dir[0] = in_ch.dir_x;
    assign in_dir[1] = in_ch.dir_y;
    assign in_dir[2] = in_ch.dir_z;
    assign in_ref[0] = in_ch.ref_x;
    assign in_ref[1] = in_ch.ref_y;
    assign in_ref[2] = in_ch.ref_z;

    always_comb
    begin
        if (corner_count < 4'(MIN_CORNERS))
            n_clamp = K_W'(MIN_CORNERS);
        else if (corner_count > 4'(MAX_CORNERS))
            n_clamp = K_W'(MAX_CORNERS);
        else
            n_clamp = K_W'(corner_count);
    end

    // cosine and sine of each corner angle, signed Q1.16 in 18 bits, worked out at elaboration
    genvar gn, gk;
    for (gn = 0; gn <= MAX_CORNERS; gn++)
    begin : g_n
        for (gk = 0; gk < MAX_CORNERS; gk++)
        begin : g_k
            if (gn >= MIN_CORNERS && gk < gn)
            begin : g_val
                localparam longint T = (longint'(gk) * 64'sd4294967296) / gn;
                localparam longint QD = (T >>> 30) & 64'sd3;
                localparam longint R = T & (Q30_ONE - 64'sd1);
                localparam longint X = (R * HALF_PI_Q30) >>> 30;
                localparam longint X2 = (X * X) / Q30_ONE;
                localparam longint TS1 = Q30_ONE - ((X2 * Q30_ONE) / Q30_ONE) / 110;
                localparam longint TS2 = Q30_ONE - ((X2 * TS1) / Q30_ONE) / 72;
                localparam longint TS3 = Q30_ONE - ((X2 * TS2) / Q30_ONE) / 42;
                localparam longint TS4 = Q30_ONE - ((X2 * TS3) / Q30_ONE) / 20;
                localparam longint TS5 = Q30_ONE - ((X2 * TS4) / Q30_ONE) / 6;
                localparam longint TC1 = Q30_ONE - ((X2 * Q30_ONE) / Q30_ONE) / 132;
                localparam longint TC2 = Q30_ONE - ((X2 * TC1) / Q30_ONE) / 90;
                localparam longint TC3 = Q30_ONE - ((X2 * TC2) / Q30_ONE) / 56;
                localparam longint TC4 = Q30_ONE - ((X2 * TC3) / Q30_ONE) / 30;
                localparam longint TC5 = Q30_ONE - ((X2 * TC4) / Q30_ONE) / 12;
                localparam longint TC6 = Q30_ONE - ((X2 * TC5) / Q30_ONE) / 2;
                localparam longint SV = (X * TS5) / Q30_ONE;
                localparam longint SVC = (SV < 0) ? 64'sd0 : ((SV > Q30_ONE) ? Q30_ONE : SV);
                localparam longint CVC = (TC6 < 0) ? 64'sd0 : ((TC6 > Q30_ONE) ? Q30_ONE : TC6);
                localparam longint S16 = (SVC + 64'sd8192) / 16384;
                localparam longint C16 = (CVC + 64'sd8192) / 16384;
                localparam longint CS = (QD == 0) ? C16 : (QD == 1) ? -S16 :
                                        (QD == 2) ? -C16 : S16;
                localparam longint SN = (QD == 0) ? S16 : (QD == 1) ? C16 :
                                        (QD == 2) ? -S16 : -C16;
                assign cos_tab[gn][gk] = 18'(CS);
                assign sin_tab[gn][gk] = 18'(SN);
            end
            else
            begin : g_zero
                assign cos_tab[gn][gk] = 18'sd0;
                assign sin_tab[gn][gk] = 18'sd0;
            end
        end
    end

    assign cs_w = cos_tab[n_reg][cmd.k];
    assign sn_w = sin_tab[n_reg][cmd.k];

    always_comb
    begin
        amax = a_reg[0];
        if (a_reg[1] > amax)
            amax = a_reg[1];
        if (a_reg[2] > amax)
            amax = a_reg[2];
    end

    assign len = r_reg[30:0];
    assign rb = r_reg + bit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {pa_reg[i][63], pa_reg[i]} - {pb_reg[i][63], pb_reg[i]};
            numf[i] = {1'b0, a_reg[i][29:0], 16'b0} + 47'(len[30:1]);
            trial[i] = {rem_reg[i][30:0], num_reg[i][16]};
            uq[i] = $signed({1'b0, quo_reg[i]});
            s37[i] = 37'(m1_reg[i]) + 37'(m2_reg[i]) + 37'sd32768;
            rnd35[i] = 35'((rp_reg[i] + 51'sd32768) >>> 16);
            psum[i] = 36'(ctr_reg[i]) + 36'(rnd35[i]);
        end
    end

    // triangle corner indices
    always_comb
    begin
        n5 = 5'(n_reg);
        ka = 5'(cmd.k) + 5'd1;
        kb = (ka < n5) ? ka + 5'd1 : 5'd1;
        if (!cmd.tri_cap)
        begin
            if (!cmd.tri_sub)
            begin
                ta = ka;
                tb = kb;
                tc = kb + n5;
            end
            else
            begin
                ta = kb + n5;
                tb = ka + n5;
                tc = ka;
            end
        end
        else
        begin
            if (!cmd.tri_sub)
            begin
                ta = 5'd0;
                tb = kb;
                tc = ka;
            end
            else
            begin
                ta = {n5[3:0], 1'b1};
                tb = ka + n5;
                tc = kb + n5;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctr_reg[i] <= in_ctr[i];
                dir_reg[i] <= in_dir[i];
                ref_reg[i] <= in_ref[i];
            end
            rgba_reg <= in_ch.end_color;
            n_reg <= n_clamp;
        end
        if (cmd.cross_mul)
        begin
            pa_reg[0] <= dir_reg[1] * ref_reg[2];
            pb_reg[0] <= dir_reg[2] * ref_reg[1];
            pa_reg[1] <= dir_reg[2] * ref_reg[0];
            pb_reg[1] <= dir_reg[0] * ref_reg[2];
            pa_reg[2] <= dir_reg[0] * ref_reg[1];
            pb_reg[2] <= dir_reg[1] * ref_reg[0];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.vec_load)
            begin
                if (!cmd.vec_sel)
                begin
                    neg_reg[i] <= ref_reg[i][31];
                    a_reg[i] <= {32'b0, ref_reg[i][31] ? 32'(-ref_reg[i]) : ref_reg[i]};
                end
                else
                begin
                    neg_reg[i] <= diff[i][64];
                    a_reg[i] <= diff[i][64] ? 64'(-diff[i]) : diff[i][63:0];
                end
            end
            else if (cmd.norm_step)
            begin
                // bring the largest magnitude into [2^29, 2^30)
                if (amax[63:38] != '0)
                    a_reg[i] <= a_reg[i] >> 8;
                else if (amax[63:30] != '0)
                    a_reg[i] <= a_reg[i] >> 1;
                else if (amax[63:21] == '0)
                    a_reg[i] <= a_reg[i] << 8;
                else
                    a_reg[i] <= a_reg[i] << 1;
            end
            if (cmd.sq)
                sq_reg[i] <= a_reg[i][29:0] * a_reg[i][29:0];
            if (cmd.div_init)
            begin
                rem_reg[i] <= 32'(numf[i][46:17]);
                num_reg[i] <= numf[i][16:0];
                quo_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                if (trial[i] >= {1'b0, len})
                begin
                    rem_reg[i] <= trial[i] - {1'b0, len};
                    quo_reg[i] <= {quo_reg[i][15:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= trial[i];
                    quo_reg[i] <= {quo_reg[i][15:0], 1'b0};
                end
                num_reg[i] <= num_reg[i] << 1;
            end
            if (cmd.vec_store || cmd.vec_zero)
            begin
                if (!cmd.vec_sel)
                    nh_reg[i] <= cmd.vec_zero ? 18'sd0 : (neg_reg[i] ? -uq[i] : uq[i]);
                else
                    sh_reg[i] <= cmd.vec_zero ? 18'sd0 : (neg_reg[i] ? -uq[i] : uq[i]);
            end
            if (cmd.ring_mul)
            begin
                m1_reg[i] <= cs_w * nh_reg[i];
                m2_reg[i] <= sn_w * sh_reg[i];
            end
            if (cmd.ring_nrm)
                nrm_reg[i] <= 19'(s37[i] >>> 16);
            if (cmd.ring_rmul)
                rp_reg[i] <= $signed({1'b0, radius}) * nrm_reg[i];
            if (cmd.ring_pos)
            begin
                if (psum[i][35:31] == 5'b00000 || psum[i][35:31] == 5'b11111)
                    pos_reg[i] <= psum[i][31:0];
                else if (psum[i][35])
                    pos_reg[i] <= 32'sh80000000;
                else
                    pos_reg[i] <= 32'sh7fffffff;
            end
        end
        if (cmd.sqrt_init)
        begin
            v_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            r_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (cmd.sqrt_step)
        begin
            if (v_reg >= rb)
            begin
                v_reg <= v_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.emit)
        begin
            olast_reg <= cmd.last;
            case (cmd.emit_sel)
                EMIT_CENTRE:
                begin
                    okind_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        opos_reg[i] <= ctr_reg[i];
                        onrm_reg[i] <= dir_reg[i];
                    end
                    orgba_reg <= rgba_reg;
                    oca_reg <= '0;
                    ocb_reg <= '0;
                    occ_reg <= '0;
                end
                EMIT_RING:
                begin
                    okind_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        opos_reg[i] <= pos_reg[i];
                        onrm_reg[i] <= 32'(nrm_reg[i]);
                    end
                    orgba_reg <= rgba_reg;
                    oca_reg <= '0;
                    ocb_reg <= '0;
                    occ_reg <= '0;
                end
                default:
                begin
                    okind_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        opos_reg[i] <= '0;
                        onrm_reg[i] <= '0;
                    end
                    orgba_reg <= '0;
                    oca_reg <= ta;
                    ocb_reg <= tb;
                    occ_reg <= tc;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit)
            ovalid_reg <= 1'b1;
        else if (out_ch.ready)
            ovalid_reg <= 1'b0;
    end

    assign stat.zero_vec = (amax == '0);
    assign stat.norm_done = (amax[63:30] == '0) && amax[29];
    assign stat.out_free = !ovalid_reg || out_ch.ready;
    assign stat.n = n_reg;

    assign out_ch.valid = ovalid_reg;
    assign out_ch.kind = okind_reg;
    assign out_ch.pos_x = opos_reg[0];
    assign out_ch.pos_y = opos_reg[1];
    assign out_ch.pos_z = opos_reg[2];
    assign out_ch.nrm_x = onrm_reg[0];
    assign out_ch.nrm_y = onrm_reg[1];
    assign out_ch.nrm_z = onrm_reg[2];
    assign out_ch.rgba = orgba_reg;
    assign out_ch.corner_a = oca_reg;
    assign out_ch.corner_b = ocb_reg;
    assign out_ch.corner_c = occ_reg;
    assign out_ch.last = olast_reg;

endmodule

`default_nettype wire

// ----- design/tmt_checker.sv -----
`default_nettype none

module tmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_kind,
    input logic       out_last,
    input logic [4:0] out_corner_a,
    input logic [4:0] out_corner_b,
    input logic [4:0] out_corner_c
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_last)
            && $stable(out_corner_a))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_vertex_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_kind |-> out_corner_a == 5'd0 && out_corner_b == 5'd0
            && out_corner_c == 5'd0)
        else $error("vertex result carries triangle indices");

endmodule

bind tube_mesh_tessellator tmt_checker u_tmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_last     (out_ch.last),
    .out_corner_a (out_ch.corner_a),
    .out_corner_b (out_ch.corner_b),
    .out_corner_c (out_ch.corner_c)
);

`default_nettype wire
